FILE: hdl/sha1bs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and round functions for the sha-1 byte stream hasher
// no dependencies

package sha1bs_pkg;

    localparam int WORD_W      = 32;
    localparam int SCHED_DEPTH = 16;
    localparam int SCHED_AW    = $clog2(SCHED_DEPTH);
    localparam int ROUND_W     = 7;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(79);
    localparam logic [ROUND_W-1:0] SCHED_LOAD = ROUND_W'(16);

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_START_IDX = 6'd56;

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
    localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word0;
        logic [WORD_W-1:0] digest_word1;
        logic [WORD_W-1:0] digest_word2;
        logic [WORD_W-1:0] digest_word3;
        logic [WORD_W-1:0] digest_word4;
    } t_out_item;

    function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
        return {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
        return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] v);
        return {v[1:0], v[WORD_W-1:2]};
    endfunction

    // round logic function, chosen by round number
    function automatic logic [WORD_W-1:0] round_f(
        input logic [ROUND_W-1:0] t,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        priority if (t < ROUND_W'(20)) begin
            f = (b & c) | (~b & d);
        end else if (t < ROUND_W'(40)) begin
            f = b ^ c ^ d;
        end else if (t < ROUND_W'(60)) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        logic [WORD_W-1:0] k;
        priority if (t < ROUND_W'(20)) begin
            k = K0;
        end else if (t < ROUND_W'(40)) begin
            k = K1;
        end else if (t < ROUND_W'(60)) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

endpackage

FILE: hdl/sha1bs_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read data
// no dependencies

module sha1bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
// sha-1 hasher taking one message byte per transaction, digest as five words
// depends on sha1bs_pkg and sha1bs_ram
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in  (msg_byte, flags)
//  output  | o_out_valid | i_out_ready | o_out (digest_word0..4)
//
// the 64th byte of a block starts a compression: a prime state for the schedule
// ram read, 80 rounds at one round per cycle, then a fold into the chaining
// words. closing a message pushes the padding (9 to 72 bytes) one byte per
// cycle, pausing for each block's compression, one or two in all, then loads
// the digest into the output register once that register is free.
// the message schedule lives in two 16-word rams, w and w[t]^w[t-2], so each
// round needs one read per ram. reset is synchronous; no clearing pass.
// the input stalls from a message close until its digest sits in the output
// register; the output register holds until taken.

module sha1_byte_stream_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sha1bs_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sha1bs_pkg::t_out_item o_out
);

    import sha1bs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_PRIME,
        S_ROUND,
        S_FINAL,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [5:0]          r_fill, n_fill;
    logic [23:0]         r_acc, n_acc;
    logic [63:0]         r_bits, n_bits;
    logic [63:0]         r_len, n_len;
    logic                r_pad_active, n_pad_active;
    logic                r_pad_first, n_pad_first;
    logic                r_len_phase, n_len_phase;
    logic                r_msg_done, n_msg_done;
    logic [ROUND_W-1:0]  r_t, n_t;
    logic [WORD_W-1:0]   r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [WORD_W-1:0]   n_h0, n_h1, n_h2, n_h3, n_h4;
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_d, r_e;
    logic [WORD_W-1:0]   n_a, n_b, n_c, n_d, n_e;
    logic [WORD_W-1:0]   r_wd1, r_wd2, r_wd3;
    logic [WORD_W-1:0]   n_wd1, n_wd2, n_wd3;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                in_acc;
    logic                push_en;
    logic [7:0]          push_byte;
    logic [WORD_W-1:0]   push_word;
    logic [WORD_W-1:0]   w_t;
    logic [WORD_W-1:0]   temp;
    logic [ROUND_W-1:0]  rd_t;

    logic                ram_we;
    logic [SCHED_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]   w_wdata, p_wdata;
    logic [SCHED_AW-1:0] w_raddr, p_raddr;
    logic [WORD_W-1:0]   w_rdata, p_rdata;

    // w[t] ring and w[t]^w[t-2] ring
    sha1bs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SCHED_DEPTH)
    ) u_w_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    sha1bs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(SCHED_DEPTH)
    ) u_p_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(p_wdata),
        .i_raddr(p_raddr),
        .o_rdata(p_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // read addresses for the round after this one: w[t] while loading, else
    // w[t-8]; the xor ring always gives w[t-14]^w[t-16]
    assign rd_t    = (r_state == S_ROUND) ? (r_t + ROUND_W'(1)) : '0;
    assign w_raddr = (rd_t < SCHED_LOAD) ? rd_t[SCHED_AW-1:0]
                                         : (rd_t[SCHED_AW-1:0] ^ SCHED_AW'(8));
    assign p_raddr = rd_t[SCHED_AW-1:0] + SCHED_AW'(2);

    assign w_t  = (r_t < SCHED_LOAD) ? w_rdata : rotl1(r_wd3 ^ w_rdata ^ p_rdata);
    assign temp = rotl5(r_a) + round_f(r_t, r_b, r_c, r_d) + r_e + round_k(r_t) + w_t;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_acc        = r_acc;
        n_bits       = r_bits;
        n_len        = r_len;
        n_pad_active = r_pad_active;
        n_pad_first  = r_pad_first;
        n_len_phase  = r_len_phase;
        n_msg_done   = r_msg_done;
        n_t          = r_t;
        n_h0         = r_h0;
        n_h1         = r_h1;
        n_h2         = r_h2;
        n_h3         = r_h3;
        n_h4         = r_h4;
        n_a          = r_a;
        n_b          = r_b;
        n_c          = r_c;
        n_d          = r_d;
        n_e          = r_e;
        n_wd1        = r_wd1;
        n_wd2        = r_wd2;
        n_wd3        = r_wd3;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        push_en   = 1'b0;
        push_byte = i_in.msg_byte;
        ram_we    = 1'b0;
        ram_waddr = r_fill[5:2];
        w_wdata   = w_t;
        p_wdata   = w_t ^ r_wd2;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.byte_present) begin
                        push_en = 1'b1;
                        n_bits  = r_bits + 64'd8;
                    end
                    if (i_in.end_of_message) begin
                        n_len        = i_in.byte_present ? (r_bits + 64'd8) : r_bits;
                        n_pad_active = 1'b1;
                        n_pad_first  = 1'b1;
                        n_state      = S_PAD;
                    end
                end
            end
            S_PAD: begin
                push_en = 1'b1;
                if (r_pad_first) begin
                    push_byte   = PAD_BYTE;
                    n_pad_first = 1'b0;
                end else if (r_len_phase || (r_fill == LEN_START_IDX)) begin
                    // length goes out msb first
                    push_byte   = r_len[63:56];
                    n_len       = {r_len[55:0], 8'h00};
                    n_len_phase = 1'b1;
                    if (r_fill == 6'd63) begin
                        n_msg_done = 1'b1;
                    end
                end else begin
                    push_byte = 8'h00;
                end
            end
            S_PRIME: begin
                n_a     = r_h0;
                n_b     = r_h1;
                n_c     = r_h2;
                n_d     = r_h3;
                n_e     = r_h4;
                n_t     = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_a   = temp;
                n_b   = r_a;
                n_c   = rotl30(r_b);
                n_d   = r_c;
                n_e   = r_d;
                n_wd1 = w_t;
                n_wd2 = r_wd1;
                n_wd3 = r_wd2;
                if (r_t >= SCHED_LOAD) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_t[SCHED_AW-1:0];
                    w_wdata   = w_t;
                    p_wdata   = w_t ^ r_wd2;
                end
                if (r_t == LAST_ROUND) begin
                    n_state = S_FINAL;
                end else begin
                    n_t = r_t + ROUND_W'(1);
                end
            end
            S_FINAL: begin
                n_h0 = r_h0 + r_a;
                n_h1 = r_h1 + r_b;
                n_h2 = r_h2 + r_c;
                n_h3 = r_h3 + r_d;
                n_h4 = r_h4 + r_e;
                priority if (r_msg_done) begin
                    n_state = S_DONE;
                end else if (r_pad_active) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.digest_word0 = r_h0;
                    n_out.digest_word1 = r_h1;
                    n_out.digest_word2 = r_h2;
                    n_out.digest_word3 = r_h3;
                    n_out.digest_word4 = r_h4;
                    n_h0               = H0_INIT;
                    n_h1               = H1_INIT;
                    n_h2               = H2_INIT;
                    n_h3               = H3_INIT;
                    n_h4               = H4_INIT;
                    n_bits             = '0;
                    n_pad_active       = 1'b0;
                    n_len_phase        = 1'b0;
                    n_msg_done         = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // shared byte push: pack into words, write each full word to both rings
        push_word = {r_acc, push_byte};
        if (push_en) begin
            n_acc  = push_word[23:0];
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'd3) begin
                ram_we  = 1'b1;
                w_wdata = push_word;
                p_wdata = push_word ^ r_wd2;
                n_wd1   = push_word;
                n_wd2   = r_wd1;
                n_wd3   = r_wd2;
            end
            if (r_fill == 6'd63) begin
                n_state = S_PRIME;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_bits       <= '0;
            r_pad_active <= 1'b0;
            r_pad_first  <= 1'b0;
            r_len_phase  <= 1'b0;
            r_msg_done   <= 1'b0;
            r_t          <= '0;
            r_h0         <= H0_INIT;
            r_h1         <= H1_INIT;
            r_h2         <= H2_INIT;
            r_h3         <= H3_INIT;
            r_h4         <= H4_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_bits       <= n_bits;
            r_pad_active <= n_pad_active;
            r_pad_first  <= n_pad_first;
            r_len_phase  <= n_len_phase;
            r_msg_done   <= n_msg_done;
            r_t          <= n_t;
            r_h0         <= n_h0;
            r_h1         <= n_h1;
            r_h2         <= n_h2;
            r_h3         <= n_h3;
            r_h4         <= n_h4;
            r_out_valid  <= n_out_valid;
        end
        r_acc <= n_acc;
        r_len <= n_len;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
        r_wd1 <= n_wd1;
        r_wd2 <= n_wd2;
        r_wd3 <= n_wd3;
        r_out <= n_out;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for sha1_byte_stream_hasher: byte messages in, digests checked
// against a sha-1 predictor kept in the bench; depends on sha1bs_pkg and the hasher rtl

module tb_top;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    sha1bs_pkg::t_in_item  i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    sha1bs_pkg::t_out_item o_out;

    // predictor state
    logic [31:0] chain_h [5];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;

    sha1bs_pkg::t_out_item pending_digests [$];

    int  errors = 0;
    int  items_sent = 0;
    int  drain_cycles;
    bit  src_idle_en;
    bit  sink_idle_en;
    int  hold_left = 0;
    int  stall_left = 0;
    logic [4:0][31:0] want_words;
    logic [4:0][31:0] got_words;

    sha1_byte_stream_hasher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void restart_chain();
        chain_h[0] = 32'h67452301;
        chain_h[1] = 32'hEFCDAB89;
        chain_h[2] = 32'h98BADCFE;
        chain_h[3] = 32'h10325476;
        chain_h[4] = 32'hC3D2E1F0;
        fill_pos = 6'd0;
        msg_bits = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        end
        for (int i = 16; i < 80; i++) begin
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] v);
        block_bytes[fill_pos] = v;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0) begin
            compress_block();
        end
    endfunction

    // advance the predictor by one accepted transaction
    function automatic void digest_predict(input sha1bs_pkg::t_in_item it);
        logic [63:0]           len_bits;
        sha1bs_pkg::t_out_item d;
        if (it.byte_present) begin
            absorb_byte(it.msg_byte);
            msg_bits = msg_bits + 64'd8;
        end
        if (it.end_of_message) begin
            len_bits = msg_bits;
            absorb_byte(8'h80);
            while (fill_pos != 6'd56) begin
                absorb_byte(8'h00);
            end
            for (int i = 0; i < 8; i++) begin
                absorb_byte(len_bits[63 - 8*i -: 8]);
            end
            d.digest_word0 = chain_h[0];
            d.digest_word1 = chain_h[1];
            d.digest_word2 = chain_h[2];
            d.digest_word3 = chain_h[3];
            d.digest_word4 = chain_h[4];
            pending_digests.push_back(d);
            restart_chain();
        end
    endfunction

    task automatic send_item(input logic [7:0] data, input logic present, input logic last);
        sha1bs_pkg::t_in_item it;
        int gap;
        it.msg_byte       = data;
        it.byte_present   = present;
        it.end_of_message = last;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        digest_predict(it);
        if (present || last) begin
            items_sent++;
        end
    endtask

    // random bytes; the close rides on the last byte or on a separate empty transaction
    task automatic send_message(input int len, input bit sep_close, input int noise_pct);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, !sep_close && n == len - 1);
        end
        if (sep_close || len == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic test_empty_message();
        send_item(8'hA5, 1'b0, 1'b1);
    endtask

    // "abc" with an ignored transaction in the middle
    task automatic test_known_text();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
    endtask

    // lengths on either side of the one- vs two-block padding split
    task automatic test_block_boundaries();
        int sizes [6] = '{55, 56, 63, 64, 119, 120};
        for (int i = 0; i < 6; i++) begin
            send_message(sizes[i], i[0], 0);
        end
    endtask

    // sink holds off long enough that the input side has to stall
    task automatic test_output_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        hold_left    = 1500;
        for (int i = 0; i < 4; i++) begin
            send_message(5, 1'b0, 0);
        end
    endtask

    task automatic test_random_messages(input int item_goal, input int min_msgs);
        int msgs;
        int len;
        int r;
        msgs = 0;
        while (items_sent < item_goal || msgs < min_msgs) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                len = 0;
            end else if (r < 80) begin
                len = $urandom_range(1, 24);
            end else if (r < 95) begin
                len = $urandom_range(25, 130);
            end else begin
                len = $urandom_range(131, 260);
            end
            src_idle_en  = ($urandom_range(0, 9) < 7);
            sink_idle_en = ($urandom_range(0, 9) < 7);
            send_message(len, $urandom_range(0, 3) == 0, 6);
            msgs++;
        end
    endtask

    task automatic test_steady_stream(input int item_goal);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        while (items_sent < item_goal) begin
            send_message($urandom_range(0, 40), $urandom_range(0, 1) == 1, 0);
        end
    endtask

    // sink side: long hold-off on request, otherwise random stall bursts
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 18);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_digests.size() == 0) begin
                $error("digest transaction with no closed message pending: %h", o_out);
                errors++;
            end else begin
                want_words = pending_digests.pop_front();
                got_words  = o_out;
                // word0 sits in the top 32 bits
                for (int i = 0; i < 5; i++) begin
                    if (got_words[4-i] !== want_words[4-i]) begin
                        $error("digest_word%0d: expected %08h, got %08h",
                               i, want_words[4-i], got_words[4-i]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        restart_chain();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_known_text();
        test_byte_extremes();
        test_block_boundaries();
        test_output_backpressure();
        test_random_messages(1500, 40);
        test_steady_stream(1650);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_digests.size() != 0 && drain_cycles < 20000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_digests.size() != 0) begin
            $error("%0d expected digests never arrived", pending_digests.size());
            errors++;
        end
        // longest close is 72 pad bytes plus two compressions
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("sha1_byte_stream_hasher test passed");
        end else begin
            $display("sha1_byte_stream_hasher test failed");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("sha1_byte_stream_hasher test failed");
        $finish;
    end

endmodule
